>>> hdl/irl_pkg.sv
// shared types and constants for the left-rotating frame rotator
package irl_pkg;

    localparam int PIX_W = 8;
    localparam int DIM_W = 9;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

endpackage

>>> hdl/irl_in_if.sv
// request channel: operation and input pixel
interface irl_in_if;
    logic                        valid;
    logic                        ready;
    irl_pkg::t_op                op;
    logic [irl_pkg::PIX_W-1:0]   pixel_in;

    modport source (output valid, output op, output pixel_in, input ready);
    modport sink (input valid, input op, input pixel_in, output ready);
endinterface

>>> hdl/irl_out_if.sv
// result channel: rotated pixel and flags
interface irl_out_if;
    logic                        valid;
    logic                        ready;
    logic [irl_pkg::PIX_W-1:0]   pixel_out;
    logic                        frame_last;
    logic                        not_ready;

    modport source (output valid, output pixel_out, output frame_last, output not_ready,
                    input ready);
    modport sink (input valid, input pixel_out, input frame_last, input not_ready,
                  output ready);
endinterface

>>> hdl/irl_frame_ram.sv
// frame store: one write port, one read port with registered read data
module irl_frame_ram #(
    parameter int MAX_ROWS = irl_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = irl_pkg::MAX_COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(MAX_ROWS)-1:0]       i_wr_row,
    input  logic [$clog2(MAX_COLS)-1:0]       i_wr_col,
    input  logic [irl_pkg::PIX_W-1:0]         i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(MAX_ROWS)-1:0]       i_rd_row,
    input  logic [$clog2(MAX_COLS)-1:0]       i_rd_col,
    output logic [irl_pkg::PIX_W-1:0]         o_rd_data
);

    logic [irl_pkg::PIX_W-1:0] r_mem [MAX_ROWS][MAX_COLS];
    logic [irl_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row][i_wr_col] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row][i_rd_col];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/image_rotate_left_90.sv
// top level of the frame rotator: counters, read pipeline and result register
//
//  channel   dir  handshake        payload
//  i_req     in   valid / ready    op, pixel_in
//  o_res     out  valid / ready    pixel_out, frame_last, not_ready
//  i_cfg     in   i_cfg_we         i_cfg_idx, i_cfg_data (image_rows, image_cols)
//
// one request per cycle: a load writes the frame ram at the edge that takes it,
// a pull reads it into the read stage, and the result register takes it once free.
// the registered read of the frame ram sets the two-stage result path.
// i_rst_n is synchronous; after it the block is in the loading phase at once.
// a stalled result holds the read stage, and a request is refused only while
// both stages are full and o_res.ready is low.
module image_rotate_left_90 #(
    parameter int MAX_ROWS = irl_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = irl_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    irl_in_if.sink                              i_req,
    irl_out_if.source                           o_res,
    input  logic                                i_cfg_we,
    input  logic [irl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [irl_pkg::DIM_W-1:0]           i_cfg_data
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);

    // dimension register value minus one, with zero counted as one and saturation
    function automatic int dim_m1(input logic [irl_pkg::DIM_W-1:0] v, input int maxv);
        int r;
        if (v == '0) begin
            r = 0;
        end else if (int'(v) > maxv) begin
            r = maxv - 1;
        end else begin
            r = int'(v) - 1;
        end
        return r;
    endfunction

    logic [ROW_W-1:0] r_rows_m1;
    logic [COL_W-1:0] r_cols_m1;
    logic             r_emitting;
    logic [ROW_W-1:0] r_load_row;
    logic [COL_W-1:0] r_load_col;
    logic [COL_W-1:0] r_emit_row;
    logic [ROW_W-1:0] r_emit_col;

    logic r_p1_valid;
    logic r_p1_last;
    logic r_p1_err;

    logic                        r_out_valid;
    logic [irl_pkg::PIX_W-1:0]   r_out_pixel;
    logic                        r_out_last;
    logic                        r_out_err;

    logic                        p1_adv;
    logic                        req_take;
    logic                        do_load;
    logic                        do_pull;
    logic                        do_err;
    logic                        emit_last;
    logic [COL_W-1:0]            src_col;
    logic [irl_pkg::PIX_W-1:0]   rd_data;

    assign p1_adv      = r_p1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_p1_valid || p1_adv;
    assign req_take    = i_req.valid && i_req.ready;

    always_comb begin
        do_load = 1'b0;
        do_pull = 1'b0;
        do_err  = 1'b0;
        unique case (i_req.op)
            irl_pkg::OP_LOAD: do_load = req_take && !r_emitting;
            irl_pkg::OP_PULL: begin
                do_pull = req_take && r_emitting;
                do_err  = req_take && !r_emitting;
            end
            default: ;
        endcase
    end

    // output row emit_row reads input column cols-1-emit_row
    assign src_col   = r_cols_m1 - r_emit_row;
    assign emit_last = (r_emit_col == r_rows_m1) && (r_emit_row == r_cols_m1);

    irl_frame_ram #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_load),
        .i_wr_row  (r_load_row),
        .i_wr_col  (r_load_col),
        .i_wr_data (i_req.pixel_in),
        .i_rd_en   (do_pull),
        .i_rd_row  (r_emit_col),
        .i_rd_col  (src_col),
        .o_rd_data (rd_data)
    );

    // dimensions, phase and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m1  <= ROW_W'(dim_m1(irl_pkg::DIM_RESET, MAX_ROWS));
            r_cols_m1  <= COL_W'(dim_m1(irl_pkg::DIM_RESET, MAX_COLS));
            r_emitting <= 1'b0;
            r_load_row <= '0;
            r_load_col <= '0;
            r_emit_row <= '0;
            r_emit_col <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                irl_pkg::CFG_ROWS: r_rows_m1 <= ROW_W'(dim_m1(i_cfg_data, MAX_ROWS));
                irl_pkg::CFG_COLS: r_cols_m1 <= COL_W'(dim_m1(i_cfg_data, MAX_COLS));
                default: ;
            endcase
            r_emitting <= 1'b0;
            r_load_row <= '0;
            r_load_col <= '0;
            r_emit_row <= '0;
            r_emit_col <= '0;
        end else if (do_load) begin
            if (r_load_col == r_cols_m1) begin
                r_load_col <= '0;
                if (r_load_row == r_rows_m1) begin
                    r_load_row <= '0;
                    r_emitting <= 1'b1;
                end else begin
                    r_load_row <= r_load_row + ROW_W'(1);
                end
            end else begin
                r_load_col <= r_load_col + COL_W'(1);
            end
        end else if (do_pull) begin
            if (r_emit_col == r_rows_m1) begin
                r_emit_col <= '0;
                if (r_emit_row == r_cols_m1) begin
                    r_emit_row <= '0;
                    r_emitting <= 1'b0;
                end else begin
                    r_emit_row <= r_emit_row + COL_W'(1);
                end
            end else begin
                r_emit_col <= r_emit_col + ROW_W'(1);
            end
        end
    end

    // read stage: waits for the ram data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (do_pull || do_err) begin
            r_p1_valid <= 1'b1;
        end else if (p1_adv) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pull || do_err) begin
            r_p1_last <= do_pull && emit_last;
            r_p1_err  <= do_err;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_adv) begin
            r_out_pixel <= r_p1_err ? '0 : rd_data;
            r_out_last  <= r_p1_last;
            r_out_err   <= r_p1_err;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pixel_out  = r_out_pixel;
    assign o_res.frame_last = r_out_last;
    assign o_res.not_ready  = r_out_err;

`ifndef SYNTH
    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit_row <= r_cols_m1) && (r_emit_col <= r_rows_m1)
        && (r_load_row <= r_rows_m1) && (r_load_col <= r_cols_m1))
        else $error("raster counter beyond frame size");

    a_load_idle_when_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting |-> (r_load_row == '0) && (r_load_col == '0))
        else $error("load counters moved while emitting");

    a_read_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && r_out_valid && !o_res.ready) |=> r_p1_valid && $stable(r_p1_last)
        && $stable(r_p1_err))
        else $error("read stage lost a pending result");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pull && emit_last && !i_cfg_we) |=> !r_emitting && (r_emit_row == '0))
        else $error("final pull did not return to loading");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_err && r_out_last))
        else $error("error result flagged as frame end");
`endif

endmodule
